// ===== design/vector_normalize_3d_top_defines.svh =====
// Assertion helpers used by the block's top-level RTL file
`ifndef VECTOR_NORMALIZE_3D_TOP_DEFINES_SVH
`define VECTOR_NORMALIZE_3D_TOP_DEFINES_SVH

// Same-cycle implication on aclk, held off during reset
`define VN3_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vn3 assertion failed");

// Next-cycle implication on aclk, held off during reset
`define VN3_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vn3 assertion failed");

`endif

// ===== design/vn3_pkg.sv =====
`default_nettype none
package vn3_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int QUOT_BITS  = 31;

    // input request
    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_t;

    // result request
    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic        [31:0] magnitude;
        logic               zero_vector;
    } out_t;

    // data carried along the root chain
    typedef struct packed {
        logic [63:0]      rem;
        logic [63:0]      root;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } sq_t;

    // data carried along the divide chain
    typedef struct packed {
        logic [31:0]                len;
        logic [2:0][32:0]           rem;
        logic [2:0][QUOT_BITS-1:0]  quot;
        logic [2:0]                 neg;
    } dv_t;

endpackage
`default_nettype wire

// ===== design/vector_normalize_3d_top.sv =====
// Channel  | Ports                       | Contents
// input    | s_valid, s_ready, s_data    | vec_x, vec_y, vec_z
// result   | m_valid, m_ready, m_data    | unit_x/y/z, magnitude, zero_vector
//
// One request accepted per cycle while no result is held waiting on the output;
// each result is offered after its request has passed through 67 register stages:
// abs, square, sum, 32 root cells, 31 divide cells, output register.
// The root and divide chains produce one result bit per cell.
// Reset clears only the valid bits of the stages.
// A result held on the output stalls the whole chain while it waits.
`default_nettype none
`include "vector_normalize_3d_top_defines.svh"
module vector_normalize_3d_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire vn3_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output vn3_pkg::out_t      m_data
);

    localparam int NS = vn3_pkg::SQRT_STEPS;
    localparam int ND = vn3_pkg::QUOT_BITS;

    logic en;

    // front stages: magnitudes, squares, sum
    logic             v0_reg, v1_reg, v2_reg;
    logic [2:0][31:0] mag0_reg, mag1_reg, mag2_reg;
    logic [2:0]       neg0_reg, neg1_reg, neg2_reg;
    logic [2:0][63:0] sq1_reg;
    logic [63:0]      sum2_reg;
    logic [2:0][31:0] mag_next;
    logic [2:0]       neg_next;
    logic [2:0][31:0] comp;

    // chains
    logic [NS:0]      sv;
    vn3_pkg::sq_t     sd [NS+1];
    logic [ND:0]      dv;
    vn3_pkg::dv_t     dd [ND+1];

    logic          out_valid_reg;
    vn3_pkg::out_t out_reg, out_next;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // absolute values and signs
    always_comb begin
        comp[0] = s_data.vec_x;
        comp[1] = s_data.vec_y;
        comp[2] = s_data.vec_z;
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = comp[i][31];
            mag_next[i] = comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag0_reg <= mag_next;
            neg0_reg <= neg_next;
            for (int i = 0; i < 3; i++) begin
                sq1_reg[i] <= 64'(mag0_reg[i]) * 64'(mag0_reg[i]);
            end
            mag1_reg <= mag0_reg;
            neg1_reg <= neg0_reg;
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // root chain
    always_comb begin
        sv[0]      = v2_reg;
        sd[0].rem  = sum2_reg;
        sd[0].root = '0;
        sd[0].mag  = mag2_reg;
        sd[0].neg  = neg2_reg;
    end

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        vn3_sqrt_cell #(.STEP(k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (sv[k]),
            .d_in      (sd[k]),
            .valid_out (sv[k+1]),
            .d_out     (sd[k+1])
        );
    end

    // divide chain, remainder starts at the component magnitude
    always_comb begin
        dv[0]      = sv[NS];
        dd[0].len  = sd[NS].root[31:0];
        dd[0].neg  = sd[NS].neg;
        dd[0].quot = '0;
        for (int i = 0; i < 3; i++) begin
            dd[0].rem[i] = {1'b0, sd[NS].mag[i]};
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        vn3_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (dv[k]),
            .d_in      (dd[k]),
            .valid_out (dv[k+1]),
            .d_out     (dd[k+1])
        );
    end

    // sign restore and zero vector override
    always_comb begin
        logic        zero;
        logic [31:0] u [3];
        zero = (dd[ND].len == 32'd0);
        for (int i = 0; i < 3; i++) begin
            u[i] = {1'b0, dd[ND].quot[i]};
            if (dd[ND].neg[i]) begin
                u[i] = ~u[i] + 32'd1;
            end
            if (zero) begin
                u[i] = '0;
            end
        end
        out_next.unit_x      = u[0];
        out_next.unit_y      = u[1];
        out_next.unit_z      = u[2];
        out_next.magnitude   = dd[ND].len;
        out_next.zero_vector = zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv[ND];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `VN3_ASSERT_IMP(a_zero_units, m_valid && m_data.zero_vector,
        m_data.unit_x == 32'sd0 && m_data.unit_y == 32'sd0 && m_data.unit_z == 32'sd0)
    `VN3_ASSERT_IMP(a_zero_mag, m_valid, m_data.zero_vector == (m_data.magnitude == 32'd0))
    `VN3_ASSERT_IMP(a_unit_range, m_valid,
        m_data.unit_x <= 32'sh4000_0000 && m_data.unit_x >= -32'sh4000_0000)
    `VN3_ASSERT_NXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule
`default_nettype wire

// ===== design/vn3_sqrt_cell.sv =====
`default_nettype none
// One digit of the integer square root: one result bit per cell
module vn3_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          valid_in,
    input  wire vn3_pkg::sq_t  d_in,
    output logic               valid_out,
    output vn3_pkg::sq_t       d_out
);

    localparam logic [63:0] BIT_VAL = 64'd1 << (62 - 2 * STEP);

    logic         valid_reg, valid_next;
    vn3_pkg::sq_t d_reg, d_next;
    logic [63:0]  trial;

    // compare and subtract for this bit
    always_comb begin
        trial  = d_in.root + BIT_VAL;
        d_next = d_in;
        if (d_in.rem >= trial) begin
            d_next.rem  = d_in.rem - trial;
            d_next.root = (d_in.root >> 1) + BIT_VAL;
        end else begin
            d_next.root = d_in.root >> 1;
        end
        valid_next = valid_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule
`default_nettype wire

// ===== design/vn3_div_cell.sv =====
`default_nettype none
// One quotient bit for each of the three lanes
module vn3_div_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          valid_in,
    input  wire vn3_pkg::dv_t  d_in,
    output logic               valid_out,
    output vn3_pkg::dv_t       d_out
);

    logic         valid_reg, valid_next;
    vn3_pkg::dv_t d_reg, d_next;
    logic [32:0]  diff;

    // restoring step per lane, remainder doubled on the way out
    always_comb begin
        d_next = d_in;
        diff   = '0;
        for (int i = 0; i < 3; i++) begin
            diff = d_in.rem[i] - {1'b0, d_in.len};
            if (d_in.rem[i] >= {1'b0, d_in.len}) begin
                d_next.rem[i]  = {diff[31:0], 1'b0};
                d_next.quot[i] = {d_in.quot[i][vn3_pkg::QUOT_BITS-2:0], 1'b1};
            end else begin
                d_next.rem[i]  = {d_in.rem[i][31:0], 1'b0};
                d_next.quot[i] = {d_in.quot[i][vn3_pkg::QUOT_BITS-2:0], 1'b0};
            end
        end
        valid_next = valid_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule
`default_nettype wire

// ===== tb/tb_vector_normalize_3d_top.sv =====
`default_nettype none

// Expected-result store for the normalise block
class norm_scoreboard;
    localparam int FRAC = 16;
    localparam int UNIT_FRAC = 30;

    vn3_pkg::out_t pending_q[$];
    int mismatches;

    function new();
        mismatches = 0;
    endfunction

    // integer square root, truncated
    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // note an accepted request and work out its result
    function void note_request(vn3_pkg::in_t req);
        logic [31:0] comp[3];
        logic [63:0] absv[3];
        logic        neg[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic [31:0] unit[3];
        vn3_pkg::out_t res;
        comp[0] = req.vec_x;
        comp[1] = req.vec_y;
        comp[2] = req.vec_z;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = comp[i][31];
            absv[i] = neg[i] ? {32'd0, (~comp[i]) + 32'd1} : {32'd0, comp[i]};
            sum = sum + absv[i] * absv[i];
        end
        len = isqrt(sum);
        res = '0;
        if (len == 0) begin
            res.zero_vector = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (len == (64'd1 << FRAC)) q = absv[i] << (UNIT_FRAC - FRAC);
                else q = (absv[i] << UNIT_FRAC) / len;
                if (neg[i]) q = (~q) + 64'd1;
                unit[i] = q[31:0];
            end
            res.unit_x = unit[0];
            res.unit_y = unit[1];
            res.unit_z = unit[2];
            res.magnitude = len[31:0];
        end
        pending_q.push_back(res);
    endfunction

    // compare a result with the oldest expectation
    function void check_result(vn3_pkg::out_t got);
        vn3_pkg::out_t exp_res;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_res = pending_q.pop_front();
        if (got.unit_x !== exp_res.unit_x || got.unit_y !== exp_res.unit_y ||
            got.unit_z !== exp_res.unit_z || got.magnitude !== exp_res.magnitude ||
            got.zero_vector !== exp_res.zero_vector) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp x=%h y=%h z=%h mag=%h zero=%b,",
                          " got x=%h y=%h z=%h mag=%h zero=%b"},
                    exp_res.unit_x, exp_res.unit_y, exp_res.unit_z, exp_res.magnitude,
                    exp_res.zero_vector, got.unit_x, got.unit_y, got.unit_z,
                    got.magnitude, got.zero_vector);
        end
    endfunction
endclass

module tb_vector_normalize_3d_top;
    localparam int LATENCY = 66;
    localparam int NUM_RANDOM = 640;
    localparam int STALL_LIMIT = 2000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    vn3_pkg::in_t s_data;
    logic m_valid;
    logic m_ready;
    vn3_pkg::out_t m_data;

    norm_scoreboard sb;
    bit sending_done;
    int idle_cycles;

    vector_normalize_3d_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // send one request and wait for acceptance
    task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge aclk);
        s_data.vec_x = x;
        s_data.vec_y = y;
        s_data.vec_z = z;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(s_data);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // random component: mostly small, sometimes full range
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h0;
            2: return $signed($urandom_range(0, 131072)) - 65536;
            3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return $signed($urandom_range(0, 33554432)) - 16777216;
        endcase
    endfunction

    // sender
    initial begin
        sb = new();
        sending_done = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero, unit lengths, extremes
        send_vector(32'h0, 32'h0, 32'h0);
        send_vector(32'h0001_0000, 32'h0, 32'h0);
        send_vector(32'h0, 32'hffff_0000, 32'h0);
        send_vector(32'h0, 32'h0, 32'h0001_0000);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_vector(32'h0000_0001, 32'h0, 32'h0);
        send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_vector(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_vector(32'h0000_9a00, 32'h0000_9a00, 32'h0000_0000);
        send_vector(32'h0003_0000, 32'h0004_0000, 32'h0);
        send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
        send_vector(32'h0, 32'h0, 32'h8000_0000);

        // drain before the random part
        while (sb.pending_q.size() != 0) @(negedge aclk);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2)
                while (sb.pending_q.size() != 0) @(negedge aclk);
            send_vector(rand_comp(), rand_comp(), rand_comp());
        end
        sending_done = 1;
    end

    // receiver stalls
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            m_ready = 1'b0;
            repeat (stall) @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // watchdog and end of run
    initial begin
        idle_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            if (sending_done && sb.pending_q.size() == 0) begin
                repeat (2 * LATENCY) @(posedge aclk);
                if (sb.mismatches == 0) begin
                    $display("Simulation PASSED");
                end else begin
                    $display("Simulation FAILED");
                end
                $finish;
            end
        end
    end
endmodule

`default_nettype wire
